// ----- sv/pc_breakpoint_unit_assert.svh -----
// Assertion macros for the breakpoint unit.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef PC_BREAKPOINT_UNIT_ASSERT_SVH
`define PC_BREAKPOINT_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PCBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define PCBU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pcbu_pkg.sv -----
// Shared types and codes for the breakpoint unit.
// No dependencies.
package pcbu_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned OCOUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK      = 3'd0,
    CMD_ADD        = 3'd1,
    CMD_REMOVE_NTH = 3'd2,
    CMD_REMOVE_ALL = 3'd3,
    CMD_STEP       = 3'd4,
    CMD_RUN        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_HALTED   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ENTRY = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic load_item;
    logic load_match;
    logic commit;
  } pcbu_cmd_t;

endpackage

// ----- sv/pc_breakpoint_unit.sv -----
// Top level of the PC breakpoint unit: stream ports, sequencer and table.
// Depends on pcbu_pkg, pcbu_ctrl, pcbu_datapath and the assertion header.
//
//   channel   | dir | contents
//   s_axis    | in  | tuser command; tdata address, oneshot, entry_index
//   m_axis    | out | tdata halt, status, mode, entry_count
//
// Each item passes through accept, compare in every table cell, and commit, in that order.
// The commit waits while the previous result sits unread in the output register.
// A new item is accepted as soon as the commit of the last one is done.
// Reset clears the count and the mode; table cells are written before use.
`include "pc_breakpoint_unit_assert.svh"
module pc_breakpoint_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // address[15:0], oneshot[16], entry_index[24:17]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // halt[0], status[2:1], mode[4:3], entry_count[9:5]
);
  import pcbu_pkg::*;

  pcbu_cmd_t         cmd;
  logic              halt;
  logic [1:0]        status;
  logic [1:0]        mode;
  logic [OCOUNT_W-1:0] entry_count;

  pcbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  pcbu_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (s_axis_tuser),
    .address_i     (s_axis_tdata[15:0]),
    .oneshot_i     (s_axis_tdata[16]),
    .entry_index_i (s_axis_tdata[24:17]),
    .halt_o        (halt),
    .status_o      (status),
    .mode_o        (mode),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {6'd0, entry_count, mode, status, halt};

  `PCBU_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `PCBU_ASSERT_NOW(a_halt_mode, m_axis_tvalid && halt, mode == MODE_HALTED, "halt without halted mode")
  `PCBU_ASSERT_NOW(a_full_count, m_axis_tvalid && status == ST_FULL, entry_count == OCOUNT_W'(DEPTH), "full below depth")
  `PCBU_ASSERT_NOW(a_err_no_halt, m_axis_tvalid && status != ST_OK, !halt, "halt with error")

endmodule

// ----- sv/pcbu_ctrl.sv -----
// Sequencer for the breakpoint unit: item accept, match, commit.
// Depends on pcbu_pkg.
module pcbu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pcbu_pkg::pcbu_cmd_t cmd_o
);
  import pcbu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.load_item  = 1'b0;
    cmd_o.load_match = 1'b0;
    cmd_o.commit     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.load_match = 1'b1;
        state_d          = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/pcbu_datapath.sv -----
// Breakpoint table cells, compare vector, mode and count registers.
// Depends on pcbu_pkg; driven by pcbu_ctrl commands.
module pcbu_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcbu_pkg::pcbu_cmd_t           cmd_i,
  input  logic [pcbu_pkg::CMD_W-1:0]    command_i,
  input  logic [pcbu_pkg::ADDR_W-1:0]   address_i,
  input  logic                          oneshot_i,
  input  logic [pcbu_pkg::IDX_W-1:0]    entry_index_i,
  output logic                          halt_o,
  output logic [1:0]                    status_o,
  output logic [1:0]                    mode_o,
  output logic [pcbu_pkg::OCOUNT_W-1:0] entry_count_o
);
  import pcbu_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              one_q;
  logic [IDX_W-1:0]  idx_q;

  logic [ADDR_W-1:0] bp_addr_q [DEPTH];
  logic              bp_one_q  [DEPTH];
  logic [CW-1:0]     count_q, count_d;
  mode_e             mode_q, mode_d;

  logic [DEPTH-1:0]  match_q, match_d;
  logic [DEPTH-1:0]  ge_q, ge_d;
  logic [DEPTH-1:0]  one_vec, low, tail, shift_v;
  logic              hit, first_one, write_en, remove_ok, full;
  logic              halt_d;
  status_e           status_d;

  logic              halt_q;
  logic [1:0]        status_q, mode_out_q;
  logic [OCOUNT_W-1:0] count_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      one_q  <= oneshot_i;
      idx_q  <= entry_index_i;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (bp_addr_q[i] == addr_q) && (CW'(i) < count_q);
      ge_d[i]    = XW'(i) >= XW'(idx_q);
      one_vec[i] = bp_one_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_match) begin
      match_q <= match_d;
      ge_q    <= ge_d;
    end
  end

  assign hit       = |match_q;
  assign low       = match_q & (~match_q + DEPTH'(1));
  assign tail      = ~((match_q - DEPTH'(1)) & ~match_q);
  assign first_one = |(low & one_vec);
  assign remove_ok = XW'(idx_q) < XW'(count_q);
  assign full      = (count_q == CW'(DEPTH));

  always_comb begin
    count_d  = count_q;
    mode_d   = mode_q;
    halt_d   = 1'b0;
    status_d = ST_OK;
    shift_v  = '0;
    write_en = 1'b0;
    unique case (cmd_q)
      CMD_CHECK: begin
        if (mode_q == MODE_HALTED) begin
          halt_d = 1'b1;
        end else if (mode_q == MODE_ACTIVE && hit) begin
          halt_d = 1'b1;
          mode_d = MODE_HALTED;
          if (first_one) begin
            shift_v = tail;
            count_d = count_q - CW'(1);
          end
        end
      end
      CMD_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          write_en = 1'b1;
          count_d  = count_q + CW'(1);
          if (mode_q == MODE_INACTIVE) mode_d = MODE_ACTIVE;
        end
      end
      CMD_REMOVE_NTH: begin
        if (!remove_ok) begin
          status_d = ST_NO_ENTRY;
        end else begin
          shift_v = ge_q;
          count_d = count_q - CW'(1);
          if (mode_q == MODE_ACTIVE && count_q == CW'(1)) mode_d = MODE_INACTIVE;
        end
      end
      CMD_REMOVE_ALL: begin
        count_d = '0;
        if (mode_q == MODE_ACTIVE) mode_d = MODE_INACTIVE;
      end
      CMD_STEP: begin
        mode_d = MODE_HALTED;
      end
      CMD_RUN: begin
        mode_d = (count_q != '0) ? MODE_ACTIVE : MODE_INACTIVE;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (write_en && count_q == CW'(g)) begin
          bp_addr_q[g] <= addr_q;
          bp_one_q[g]  <= one_q;
        end else if (shift_v[g]) begin
          if (g < DEPTH - 1) begin
            bp_addr_q[g] <= bp_addr_q[(g + 1) % DEPTH];
            bp_one_q[g]  <= bp_one_q[(g + 1) % DEPTH];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= MODE_INACTIVE;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      halt_q      <= halt_d;
      status_q    <= status_d;
      mode_out_q  <= mode_d;
      count_out_q <= OCOUNT_W'(count_d);
    end
  end

  assign halt_o        = halt_q;
  assign status_o      = status_q;
  assign mode_o        = mode_out_q;
  assign entry_count_o = count_out_q;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for pc_breakpoint_unit: drives items on the slave stream and
// checks every result on the master stream against an in-bench breakpoint table model.
// Depends on pcbu_pkg and the pc_breakpoint_unit RTL.
module tb;
  import pcbu_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ITEM_LATENCY = 8;

  typedef struct {
    logic        halt;
    status_e     status;
    mode_e       mode;
    logic [4:0]  count;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // address[15:0], oneshot[16], entry_index[24:17]
  logic [2:0]  s_axis_tuser = '0;  // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // halt[0], status[2:1], mode[4:3], entry_count[9:5]

  logic [15:0] bp_addr_q [TABLE_DEPTH];
  logic        bp_shot_q [TABLE_DEPTH];
  int          bp_count = 0;
  mode_e       bp_mode = MODE_INACTIVE;

  verdict_t verdicts_pending[$];
  bit       idle_en = 1'b1;
  int       stall_left = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_halts = 0;
  int       n_full = 0;
  int       n_no_entry = 0;
  int       n_errors = 0;

  pc_breakpoint_unit #(.DEPTH(TABLE_DEPTH)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void drop_entry(input int pos);
    int j;
    for (j = pos; j < bp_count - 1; j++) begin
      bp_addr_q[j] = bp_addr_q[j+1];
      bp_shot_q[j] = bp_shot_q[j+1];
    end
    bp_count--;
  endfunction

  function automatic verdict_t apply_command(input logic [2:0] cmd, input logic [15:0] addr,
                                             input logic one, input logic [7:0] idx);
    verdict_t v;
    int i;
    logic hit;
    v.halt = 1'b0;
    v.status = ST_OK;
    hit = 1'b0;
    case (cmd)
      CMD_CHECK: begin
        if (bp_mode == MODE_HALTED) begin
          v.halt = 1'b1;
        end else if (bp_mode == MODE_ACTIVE) begin
          for (i = 0; i < bp_count && !hit; i++) begin
            if (bp_addr_q[i] == addr) begin
              hit = 1'b1;
              if (bp_shot_q[i]) drop_entry(i);
              bp_mode = MODE_HALTED;
              v.halt = 1'b1;
            end
          end
        end
      end
      CMD_ADD: begin
        if (bp_count >= TABLE_DEPTH) begin
          v.status = ST_FULL;
        end else begin
          bp_addr_q[bp_count] = addr;
          bp_shot_q[bp_count] = one;
          bp_count++;
          if (bp_mode == MODE_INACTIVE) bp_mode = MODE_ACTIVE;
        end
      end
      CMD_REMOVE_NTH: begin
        if (int'(idx) >= bp_count) begin
          v.status = ST_NO_ENTRY;
        end else begin
          drop_entry(int'(idx));
          if (bp_mode == MODE_ACTIVE && bp_count == 0) bp_mode = MODE_INACTIVE;
        end
      end
      CMD_REMOVE_ALL: begin
        bp_count = 0;
        if (bp_mode == MODE_ACTIVE) bp_mode = MODE_INACTIVE;
      end
      CMD_STEP: bp_mode = MODE_HALTED;
      CMD_RUN: bp_mode = (bp_count != 0) ? MODE_ACTIVE : MODE_INACTIVE;
      default: ;
    endcase
    v.mode = bp_mode;
    v.count = bp_count[4:0];
    return v;
  endfunction

  function automatic logic [15:0] pick_pc();
    if (bp_count > 0 && $urandom_range(0, 3) != 0)
      return bp_addr_q[$urandom_range(0, bp_count - 1)];
    return 16'($urandom);
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [15:0] addr,
                           input logic one, input logic [7:0] idx);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, idx, one, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    verdicts_pending.push_back(apply_command(cmd, addr, one, idx));
    n_sent++;
  endtask

  task automatic send_random_item();
    int r;
    logic [2:0] cmd;
    logic [15:0] addr;
    logic [7:0] idx;
    r = $urandom_range(0, 99);
    addr = 16'($urandom);
    idx = 8'($urandom);
    if (r < 40) begin
      cmd = CMD_CHECK;
      addr = pick_pc();
    end else if (r < 60) begin
      cmd = CMD_ADD;
      if ($urandom_range(0, 3) == 0) addr = pick_pc();
    end else if (r < 70) begin
      cmd = CMD_REMOVE_NTH;
      if ($urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, bp_count));
    end else if (r < 73) begin
      cmd = CMD_REMOVE_ALL;
    end else if (r < 81) begin
      cmd = CMD_STEP;
    end else if (r < 96) begin
      cmd = CMD_RUN;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end
    send_item(cmd, addr, 1'($urandom_range(0, 1)), idx);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t exp_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_pending.size() == 0) begin
        $error("result with no item pending: tdata %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_v = verdicts_pending.pop_front();
        n_checked++;
        if (m_axis_tdata[0]) n_halts++;
        if (m_axis_tdata[2:1] == ST_FULL) n_full++;
        if (m_axis_tdata[2:1] == ST_NO_ENTRY) n_no_entry++;
        if (m_axis_tdata[0] !== exp_v.halt) begin
          $error("halt: expected %0d, got %0d", exp_v.halt, m_axis_tdata[0]);
          n_errors++;
        end
        if (m_axis_tdata[2:1] !== exp_v.status) begin
          $error("status: expected %0d, got %0d", exp_v.status, m_axis_tdata[2:1]);
          n_errors++;
        end
        if (m_axis_tdata[4:3] !== exp_v.mode) begin
          $error("mode: expected %0d, got %0d", exp_v.mode, m_axis_tdata[4:3]);
          n_errors++;
        end
        if (m_axis_tdata[9:5] !== exp_v.count) begin
          $error("entry_count: expected %0d, got %0d", exp_v.count, m_axis_tdata[9:5]);
          n_errors++;
        end
      end
    end
  end

  task automatic test_mode_changes();
    send_item(CMD_CHECK, 16'hFFFF, 1'b1, 8'hFF);
    send_item(CMD_RUN, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_STEP, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_CHECK, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_ADD, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_REMOVE_ALL, 16'hFFFF, 1'b1, 8'hFF);
    send_item(CMD_RUN, 16'h0000, 1'b0, 8'h00);
  endtask

  task automatic test_match_and_oneshot();
    send_item(CMD_ADD, 16'hFFFF, 1'b1, 8'h00);
    send_item(CMD_ADD, 16'h1234, 1'b0, 8'h00);
    send_item(CMD_CHECK, 16'h5555, 1'b0, 8'h00);
    send_item(CMD_CHECK, 16'hFFFF, 1'b0, 8'h00);
    send_item(CMD_RUN, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_CHECK, 16'h1234, 1'b0, 8'h00);
    send_item(CMD_RUN, 16'h0000, 1'b0, 8'h00);
  endtask

  task automatic test_remove_cases();
    send_item(CMD_REMOVE_NTH, 16'h0000, 1'b0, 8'hFF);
    send_item(CMD_REMOVE_NTH, 16'h0000, 1'b0, 8'h01);
    send_item(CMD_REMOVE_NTH, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_ADD, 16'hA5A5, 1'b1, 8'h00);
    send_item(CMD_CHECK, 16'hA5A5, 1'b0, 8'h00);
    send_item(CMD_CHECK, 16'h0001, 1'b0, 8'h00);
    send_item(CMD_REMOVE_ALL, 16'h0000, 1'b0, 8'h00);
    send_item(CMD_ADD, 16'h5A5A, 1'b0, 8'h00);
    send_item(CMD_REMOVE_ALL, 16'h0000, 1'b0, 8'h00);
  endtask

  task automatic test_spare_commands();
    send_item(CMD_SPARE6, 16'hFFFF, 1'b1, 8'hFF);
    send_item(CMD_SPARE7, 16'h0000, 1'b0, 8'h00);
  endtask

  task automatic test_full_table();
    int k;
    repeat (2) begin
      send_item(CMD_REMOVE_ALL, 16'($urandom), 1'($urandom), 8'($urandom));
      while (bp_count < TABLE_DEPTH)
        send_item(CMD_ADD, 16'($urandom), 1'($urandom), 8'($urandom));
      repeat (3) send_item(CMD_ADD, 16'($urandom), 1'($urandom), 8'($urandom));
      send_item(CMD_REMOVE_NTH, 16'($urandom), 1'($urandom), 8'(TABLE_DEPTH));
      send_item(CMD_REMOVE_NTH, 16'($urandom), 1'($urandom), 8'(TABLE_DEPTH - 1));
      send_item(CMD_ADD, 16'($urandom), 1'($urandom), 8'($urandom));
      for (k = 0; k < 12; k++) begin
        send_item(CMD_RUN, 16'($urandom), 1'($urandom), 8'($urandom));
        send_item(CMD_CHECK, pick_pc(), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic(input int n, input bit allow_idle);
    int done;
    int burst;
    done = 0;
    while (done < n) begin
      burst = $urandom_range(20, 60);
      idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      repeat (burst) send_random_item();
      done += burst;
    end
  endtask

  task automatic finish_run();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdicts_pending.size() != 0) @(posedge clk_i);
    repeat (ITEM_LATENCY) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results: %0d halts, %0d full, %0d no-entry.",
             n_sent, n_checked, n_halts, n_full, n_no_entry);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_mode_changes();
    test_match_and_oneshot();
    test_remove_cases();
    test_spare_commands();
    test_full_table();
    test_random_traffic(700, 1'b1);
    idle_en = 1'b0;
    test_random_traffic(160, 1'b0);
    finish_run();
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/pcbu_pkg.sv
sv/pcbu_ctrl.sv
sv/pcbu_datapath.sv
sv/pc_breakpoint_unit.sv
bench/tb.sv
